// ----- rtl/indexed_min_heap_queue_core_defines.svh -----
// Assertion macros used by the heap queue datapath.
`ifndef INDEXED_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define IMHQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define IMHQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imhq_pkg.sv -----
// Shared types, codes and helpers of the indexed min-heap queue.
`default_nettype none
package imhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_COUNT = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 8;
  localparam int DATE_W   = 27;
  localparam int MIN_W    = 11;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FND  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   tag;
    logic [DATE_W-1:0] date;
    logic [MIN_W-1:0]  mins;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_DEC, OP_DROP, OP_LOAD, OP_UPRD, OP_UPCMP,
    OP_SKRD, OP_SKL, OP_SKR, OP_WR, OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    NX_DONE, NX_UP, NX_DROP
  } next_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    next_e dec_next;
    logic  drop_end;
    logic  k_zero;
    logic  no_sink;
    logic  up_less;
    logic  l_out;
    logic  sk_stop;
    logic  out_free;
  } dp_sts_t;

  // Order by date, then minutes; strict.
  function automatic logic key_less(entry_t a, entry_t b);
    logic res;
    if (a.date != b.date) begin
      res = a.date < b.date;
    end else begin
      res = a.mins < b.mins;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/imhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/imhq_ctrl.sv -----
// Sequencer of the heap queue: steps the datapath through each command.
`default_nettype none
module imhq_ctrl
  import imhq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DROP  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_UPRD  = 4'd4;
  localparam logic [3:0] S_UPCMP = 4'd5;
  localparam logic [3:0] S_SKRD  = 4'd6;
  localparam logic [3:0] S_SKL   = 4'd7;
  localparam logic [3:0] S_SKR   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = OP_DEC;
        unique case (sts_i.dec_next)
          NX_UP:   state_d = S_UPRD;
          NX_DROP: state_d = S_DROP;
          default: state_d = S_DONE;
        endcase
      end
      S_DROP: begin
        cmd_o.op = OP_DROP;
        state_d  = sts_i.drop_end ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_UPRD;
      end
      S_UPRD: begin
        cmd_o.op = OP_UPRD;
        if (!sts_i.k_zero) begin
          state_d = S_UPCMP;
        end else begin
          state_d = sts_i.no_sink ? S_WR : S_SKRD;
        end
      end
      S_UPCMP: begin
        cmd_o.op = OP_UPCMP;
        if (sts_i.up_less) begin
          state_d = S_UPRD;
        end else begin
          state_d = sts_i.no_sink ? S_WR : S_SKRD;
        end
      end
      S_SKRD: begin
        cmd_o.op = OP_SKRD;
        state_d  = sts_i.l_out ? S_WR : S_SKL;
      end
      S_SKL: begin
        cmd_o.op = OP_SKL;
        state_d  = S_SKR;
      end
      S_SKR: begin
        cmd_o.op = OP_SKR;
        state_d  = sts_i.sk_stop ? S_WR : S_SKRD;
      end
      S_WR: begin
        cmd_o.op = OP_WR;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/imhq_dp.sv -----
// Heap queue datapath: heap and slot RAMs, id flags, sift registers, result register.
`default_nettype none
`include "indexed_min_heap_queue_core_defines.svh"
module imhq_dp
  import imhq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic [CMD_W-1:0]    in_cmd_i,
  input  wire logic [ID_W-1:0]     in_id_i,
  input  wire logic [DATE_W-1:0]   in_date_i,
  input  wire logic [MIN_W-1:0]    in_mins_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STAT_W-1:0]        out_status_o,
  output entry_t                   out_entry_o,
  output logic [CNT_W-1:0]         out_count_o
);

  logic [CMD_W-1:0]    cmd_q;
  logic [ID_W-1:0]     id_q;
  entry_t              cur_q, shown_q, bestval_q;
  logic [STAT_W-1:0]   status_q;
  logic [SLOT_W-1:0]   k_q, best_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ID_COUNT-1:0] present_q;
  logic                no_sink_q, r_in_q, out_valid_q;

  entry_t              heap_rd, heap_wdata, bestval_n;
  logic                heap_we;
  logic [SLOT_W-1:0]   heap_raddr, heap_waddr, parent, best_n, slot_rd;
  logic [SLOT_W+1:0]   l_idx, r_idx;
  logic                l_out, r_in, up_less, l_less, r_less, sk_stop, drop_end;
  logic [CNT_W-1:0]    last;
  next_e               dec_next;
  logic                dec_ins;

  imhq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rd)
  );

  // Every heap write also records the entry's slot under its tag.
  imhq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_COUNT)) u_slot (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_wdata.tag),
    .wdata_i (heap_waddr),
    .raddr_i (in_id_i),
    .rdata_o (slot_rd)
  );

  assign parent   = SLOT_W'((k_q - SLOT_W'(1)) >> 1);
  assign l_idx    = {1'b0, k_q, 1'b1};
  assign r_idx    = l_idx + (SLOT_W+2)'(1);
  assign l_out    = l_idx >= (SLOT_W+2)'(cnt_q);
  assign r_in     = r_idx < (SLOT_W+2)'(cnt_q);
  assign last     = cnt_q - CNT_W'(1);
  assign drop_end = (CNT_W'(k_q) == last);
  assign up_less  = key_less(cur_q, heap_rd);
  assign l_less   = key_less(heap_rd, cur_q);
  assign r_less   = r_in_q && key_less(heap_rd, bestval_q);
  assign best_n   = r_less ? r_idx[SLOT_W-1:0] : best_q;
  assign bestval_n = r_less ? heap_rd : bestval_q;
  assign sk_stop  = (best_n == k_q);
  assign dec_ins  = (cmd_i.op == OP_DEC) && (cmd_q == CMD_INSERT) && (dec_next == NX_UP);

  always_comb begin
    unique case (cmd_i.op)
      OP_DROP: heap_raddr = last[SLOT_W-1:0];
      OP_UPRD: heap_raddr = parent;
      OP_SKRD: heap_raddr = l_idx[SLOT_W-1:0];
      OP_SKL:  heap_raddr = r_idx[SLOT_W-1:0];
      default: heap_raddr = '0;
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = k_q;
    heap_wdata = cur_q;
    unique case (cmd_i.op)
      OP_UPCMP: begin
        heap_we    = up_less;
        heap_wdata = heap_rd;
      end
      OP_SKR: begin
        heap_we    = !sk_stop;
        heap_wdata = bestval_n;
      end
      OP_WR:   heap_we = 1'b1;
      default: heap_we = 1'b0;
    endcase
  end

  always_comb begin
    dec_next = NX_DONE;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (!present_q[id_q] && (cnt_q != CNT_W'(CAPACITY))) begin
          dec_next = NX_UP;
        end
      end
      CMD_EXTRACT: begin
        if (cnt_q != '0) begin
          dec_next = NX_DROP;
        end
      end
      CMD_REMOVE: begin
        if (present_q[id_q] && (CNT_W'(slot_rd) < cnt_q)) begin
          dec_next = NX_DROP;
        end
      end
      default: dec_next = NX_DONE;
    endcase
  end

  always_comb begin
    sts_o.dec_next = dec_next;
    sts_o.drop_end = drop_end;
    sts_o.k_zero   = (k_q == '0);
    sts_o.no_sink  = no_sink_q;
    sts_o.up_less  = up_less;
    sts_o.l_out    = l_out;
    sts_o.sk_stop  = sk_stop;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        cmd_q    <= in_cmd_i;
        id_q     <= in_id_i;
        cur_q    <= '{tag: in_id_i, date: in_date_i, mins: in_mins_i};
        shown_q  <= '0;
        status_q <= ST_OK;
      end
      OP_DEC: begin
        unique case (cmd_q)
          CMD_INSERT: begin
            if (present_q[id_q]) begin
              status_q <= ST_DUP;
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              status_q <= ST_FULL;
            end else begin
              k_q <= cnt_q[SLOT_W-1:0];
            end
          end
          CMD_EXTRACT, CMD_PEEK: begin
            if (cnt_q == '0) begin
              status_q <= ST_EMPTY;
            end else begin
              shown_q <= heap_rd;
              k_q     <= '0;
            end
          end
          CMD_REMOVE: begin
            if (dec_next == NX_DROP) begin
              k_q <= slot_rd;
            end else begin
              status_q <= ST_NOT_FND;
            end
          end
          default: status_q <= ST_OK;
        endcase
      end
      OP_LOAD:  cur_q <= heap_rd;
      OP_UPCMP: begin
        if (up_less) begin
          k_q <= parent;
        end
      end
      OP_SKL: begin
        best_q    <= l_less ? l_idx[SLOT_W-1:0] : k_q;
        bestval_q <= l_less ? heap_rd : cur_q;
        r_in_q    <= r_in;
      end
      OP_SKR: begin
        if (!sk_stop) begin
          k_q <= best_n;
        end
      end
      OP_OUT: begin
        out_status_o <= status_q;
        out_entry_o  <= shown_q;
        out_count_o  <= cnt_q;
      end
      default: cur_q <= cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      present_q   <= '0;
      no_sink_q   <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_DEC: begin
          unique case (cmd_q)
            CMD_INSERT: begin
              if (dec_next == NX_UP) begin
                cnt_q           <= cnt_q + CNT_W'(1);
                present_q[id_q] <= 1'b1;
                no_sink_q       <= 1'b1;
              end
            end
            CMD_EXTRACT: begin
              if (dec_next == NX_DROP) begin
                present_q[heap_rd.tag] <= 1'b0;
              end
            end
            CMD_REMOVE: begin
              if (dec_next == NX_DROP) begin
                present_q[id_q] <= 1'b0;
              end
            end
            CMD_CLEAR: begin
              cnt_q     <= '0;
              present_q <= '0;
            end
            default: no_sink_q <= no_sink_q;
          endcase
        end
        OP_DROP: begin
          cnt_q     <= last;
          no_sink_q <= 1'b0;
        end
        OP_UPCMP: begin
          if (up_less) begin
            no_sink_q <= 1'b1;
          end
        end
        default: no_sink_q <= no_sink_q;
      endcase
    end
  end

  // Result valid: set on load, cleared once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `IMHQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `IMHQ_ASSERT(a_drop_nonempty, (cmd_i.op != OP_DROP) || (cnt_q != '0), "drop on empty heap")
  `IMHQ_ASSERT_NEXT(a_ins_flag, dec_ins, present_q[id_q], "inserted id not flagged")
  `IMHQ_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q, "pending result lost")

endmodule
`default_nettype wire

// ----- rtl/indexed_min_heap_queue_core.sv -----
// Top level of the indexed min-heap priority queue.
// Binary min-heap of up to 64 entries (8-bit id, 27-bit date, 11-bit minutes), ordered by
// date then minutes with a strict compare, plus a slot-per-id table so any id can be
// removed. One command transaction in gives exactly one result transaction out. The heap
// RAM has a single read port with registered data, so each command steps through states:
// accept and decode, then per sift-up level a parent read and a compare, per sift-down
// level the left child read, the right child read and the pick, then the final write and
// the result load. Insert climbs from the new last slot; extract sinks from the root;
// remove that starts below the root first checks the parent and climbs, else sinks.
// A new command is taken once the previous one has been handed to the output register,
// so a waiting result does not block accepting the next command, only its hand-off.
// The id flags are cleared at reset and by clear; heap and slot RAMs need no clearing.
`default_nettype none
module indexed_min_heap_queue_core
  import imhq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[2:0], item_id[10:3], date_key[37:11], start_minutes[48:38], zero pad [55:49]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], out_id[10:3], out_date[37:11], out_minutes[48:38], occupancy[55:49]
  output logic [55:0]      m_axis_tdata
);

  dp_cmd_t             dp_cmd;
  dp_sts_t             dp_sts;
  logic [STAT_W-1:0]   res_status;
  entry_t              res_entry;
  logic [CNT_W-1:0]    res_count;

  imhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  imhq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .in_cmd_i     (s_axis_tdata[2:0]),
    .in_id_i      (s_axis_tdata[10:3]),
    .in_date_i    (s_axis_tdata[37:11]),
    .in_mins_i    (s_axis_tdata[48:38]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_entry_o  (res_entry),
    .out_count_o  (res_count)
  );

  // Result transaction: fields packed from the low bit up.
  assign m_axis_tdata = {res_count, res_entry.mins, res_entry.date, res_entry.tag, res_status};

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the indexed min-heap priority queue core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import imhq_pkg::*;

  // Command stream in, one result transaction per command out. A local heap
  // model or a typed table row gives each result; checked in order, by field.

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [DATE_W-1:0] date;
    logic [MIN_W-1:0]  mins;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [DATE_W-1:0] date;
    logic [MIN_W-1:0]  mins;
    logic [CNT_W-1:0]  occ;
  } res_t;

  typedef struct {
    cmd_t c;
    logic typed;  // expected result typed in the table
    res_t r;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  indexed_min_heap_queue_core u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Heap model
  entry_t                heap_q [CAPACITY];
  logic [SLOT_W-1:0]     slot_q [ID_COUNT];
  logic                  present_q [ID_COUNT];
  int unsigned           count_q;

  res_t expected_q [$];
  int   errors;
  int   send_idle_pct, recv_idle_pct;
  bit   hold_off;
  longint cycles = 0;

  function automatic bit earlier(entry_t a, entry_t b);
    if (a.date != b.date) return a.date < b.date;
    return a.mins < b.mins;
  endfunction

  function automatic void put(int unsigned s, entry_t e);
    heap_q[s] = e;
    slot_q[e.tag] = s[SLOT_W-1:0];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_q[a];
    put(a, heap_q[b]);
    put(b, t);
  endfunction

  function automatic void sift_up(int unsigned k);
    int unsigned p;
    while (k > 0) begin
      p = (k - 1) / 2;
      if (!earlier(heap_q[k], heap_q[p])) break;
      swap_slots(k, p);
      k = p;
    end
  endfunction

  function automatic void sift_down(int unsigned k);
    int unsigned b, l;
    forever begin
      b = k;
      l = 2 * k + 1;
      if (l < count_q && earlier(heap_q[l], heap_q[b])) b = l;
      if (l + 1 < count_q && earlier(heap_q[l+1], heap_q[b])) b = l + 1;
      if (b == k) break;
      swap_slots(k, b);
      k = b;
    end
  endfunction

  function automatic void take_slot(int unsigned k);
    int unsigned last;
    last = count_q - 1;
    present_q[heap_q[k].tag] = 1'b0;
    count_q = last;
    if (k != last) begin
      put(k, heap_q[last]);
      if (k > 0 && earlier(heap_q[k], heap_q[(k-1)/2])) sift_up(k);
      else sift_down(k);
    end
  endfunction

  function automatic res_t heap_apply(cmd_t c);
    res_t r;
    entry_t e;
    r = '{default: '0};
    case (c.cmd)
      CMD_INSERT: begin
        if (present_q[c.id]) r.status = ST_DUP;
        else if (count_q >= CAPACITY) r.status = ST_FULL;
        else begin
          e.tag = c.id; e.date = c.date; e.mins = c.mins;
          put(count_q, e);
          present_q[c.id] = 1'b1;
          count_q++;
          sift_up(count_q - 1);
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (count_q == 0) r.status = ST_EMPTY;
        else begin
          r.id = heap_q[0].tag; r.date = heap_q[0].date; r.mins = heap_q[0].mins;
          if (c.cmd == CMD_EXTRACT) take_slot(0);
        end
      end
      CMD_REMOVE: begin
        if (!present_q[c.id] || slot_q[c.id] >= count_q) r.status = ST_NOT_FND;
        else take_slot(slot_q[c.id]);
      end
      CMD_CLEAR: begin
        count_q = 0;
        foreach (present_q[i]) present_q[i] = 1'b0;
      end
      default: ;
    endcase
    r.occ = count_q[CNT_W-1:0];
    return r;
  endfunction

  // Drive one command transaction and queue its expected result.
  task automatic send_cmd(cmd_t c, logic typed, res_t tr);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    r = heap_apply(c);
    if (typed && r != tr)
      $display("%0t table row disagrees with model: exp %p got %p", $time, tr, r);
    expected_q = {expected_q, (typed ? tr : r)};
    s_axis_tdata  <= {7'd0, c.mins, c.date, c.id, c.cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    res_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[37:11],
              m_axis_tdata[48:38], m_axis_tdata[55:49]};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result transaction %p", $time, got);
        errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.status != exp.status || got.id != exp.id || got.date != exp.date ||
            got.mins != exp.mins || got.occ != exp.occ) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp, got);
          errors++;
        end
      end
    end
  end

  // Receiver ready, with random stalls and long hold-off
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [CMD_W-1:0] c, logic [ID_W-1:0] i,
                              logic [DATE_W-1:0] d, logic [MIN_W-1:0] m);
    cmd_t x;
    x.cmd = c; x.id = i; x.date = d; x.mins = m;
    return x;
  endfunction

  function automatic res_t rs(logic [STAT_W-1:0] s, logic [ID_W-1:0] i,
                              logic [DATE_W-1:0] d, logic [MIN_W-1:0] m,
                              logic [CNT_W-1:0] o);
    res_t x;
    x.status = s; x.id = i; x.date = d; x.mins = m; x.occ = o;
    return x;
  endfunction

  // Random command, mostly well formed, biased to a small id set and small key ranges
  function automatic cmd_t rand_cmd(int phase);
    cmd_t c;
    int unsigned p;
    p = $urandom_range(99);
    c.id   = (phase % 2) ? ID_W'($urandom) : ID_W'($urandom_range(15) * 17);
    c.date = ($urandom_range(3) == 0) ? DATE_W'($urandom) : DATE_W'($urandom_range(3));
    c.mins = ($urandom_range(3) == 0) ? MIN_W'($urandom) : MIN_W'($urandom_range(2));
    if (p < 45) c.cmd = CMD_INSERT;
    else if (p < 65) c.cmd = CMD_EXTRACT;
    else if (p < 75) c.cmd = CMD_PEEK;
    else if (p < 95) c.cmd = CMD_REMOVE;
    else if (p < 97) c.cmd = CMD_CLEAR;
    else c.cmd = CMD_W'($urandom_range(7, 5));
    return c;
  endfunction

  row_t table_q [$];

  initial begin
    int wait_n;
    errors = 0; hold_off = 0;
    send_idle_pct = 27; recv_idle_pct = 54;
    count_q = 0;
    foreach (present_q[i]) present_q[i] = 1'b0;
    foreach (slot_q[i]) slot_q[i] = '0;

    // Directed: extremes, every command, the empty, not-found and duplicate errors, unused codes
    table_q = '{
      '{mk(CMD_EXTRACT, 0, 0, 0), 1, rs(ST_EMPTY, 0, 0, 0, 0)},
      '{mk(CMD_PEEK, 0, 0, 0), 1, rs(ST_EMPTY, 0, 0, 0, 0)},
      '{mk(CMD_REMOVE, 8'hFF, 0, 0), 1, rs(ST_NOT_FND, 0, 0, 0, 0)},
      '{mk(CMD_INSERT, 8'hFF, 27'h7FFFFFF, 11'h7FF), 1, rs(ST_OK, 0, 0, 0, 1)},
      '{mk(CMD_PEEK, 0, 0, 0), 1, rs(ST_OK, 8'hFF, 27'h7FFFFFF, 11'h7FF, 1)},
      '{mk(CMD_INSERT, 8'hFF, 0, 0), 1, rs(ST_DUP, 0, 0, 0, 1)},
      '{mk(CMD_INSERT, 0, 0, 0), 1, rs(ST_OK, 0, 0, 0, 2)},
      '{mk(CMD_INSERT, 8'h55, 0, 0), 0, '{default: '0}},
      '{mk(CMD_INSERT, 8'hAA, 0, 11'd1439), 0, '{default: '0}},
      '{mk(CMD_INSERT, 8'h0F, 27'h5555555, 11'h555), 0, '{default: '0}},
      '{mk(CMD_INSERT, 8'hF0, 27'h2AAAAAA, 11'h2AA), 0, '{default: '0}},
      '{mk(3'd5, 8'hFF, 27'h7FFFFFF, 11'h7FF), 0, '{default: '0}},
      '{mk(3'd6, 0, 0, 0), 0, '{default: '0}},
      '{mk(3'd7, 0, 0, 0), 0, '{default: '0}},
      '{mk(CMD_REMOVE, 8'h55, 0, 0), 0, '{default: '0}},
      '{mk(CMD_REMOVE, 8'h55, 0, 0), 0, '{default: '0}},
      '{mk(CMD_EXTRACT, 0, 0, 0), 0, '{default: '0}},
      '{mk(CMD_EXTRACT, 0, 0, 0), 0, '{default: '0}},
      '{mk(CMD_CLEAR, 0, 0, 0), 1, rs(ST_OK, 0, 0, 0, 0)},
      '{mk(CMD_REMOVE, 8'hFF, 0, 0), 1, rs(ST_NOT_FND, 0, 0, 0, 0)}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_q[i]) send_cmd(table_q[i].c, table_q[i].typed, table_q[i].r);

    // Fill to capacity and beyond to hit the full flag
    for (int i = 0; i < CAPACITY + 2; i++)
      send_cmd(mk(CMD_INSERT, i[7:0], DATE_W'($urandom_range(40)),
                  MIN_W'($urandom_range(1439))), 0, '0);
    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send_cmd(rand_cmd(1), 0, '0);
    join
    for (int i = 0; i < 40; i++) send_cmd(mk(CMD_EXTRACT, 0, 0, 0), 0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 27 : 0;
      for (int i = 0; i < 100; i++) send_cmd(rand_cmd(i), 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait_n = 0;
    while (expected_q.size() != 0 && wait_n < 20000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
